### sv/ff1_pkg.sv
// ----------------------------------------------------------------------------
// FF1 package
// AES tables and round helpers shared by the FF1 radix-2 encryptor.
// ----------------------------------------------------------------------------
`default_nettype none

package ff1_pkg;

   localparam int unsigned MaxTweakBytes = 16;
   localparam int unsigned FeistelRounds = 10;
   localparam int unsigned AesRounds     = 10;

   typedef enum logic [2:0] {
      CSR_KEY_HIGH   = 3'd0,
      CSR_KEY_LOW    = 3'd1,
      CSR_TWEAK_HIGH = 3'd2,
      CSR_TWEAK_LOW  = 3'd3,
      CSR_TWEAK_LEN  = 3'd4
   } csr_index_type;

   localparam logic [7:0] SBOX [256] = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
   };

   localparam logic [7:0] RCON [10] = '{
      8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,8'h80,8'h1b,8'h36
   };

   function automatic logic [7:0] xtime(input logic [7:0] x);
      return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
   endfunction

   // Byte 0 of the state sits in bits 127:120.
   function automatic logic [127:0] aes_round(input logic [127:0] s,
                                              input logic [127:0] rk,
                                              input logic last);
      logic [7:0] b [16];
      logic [7:0] t [16];
      logic [7:0] m [16];
      logic [7:0] all;
      logic [127:0] o;
      for (int k = 0; k < 16; k++) b[k] = SBOX[s[127-8*k -: 8]];
      for (int c = 0; c < 4; c++)
         for (int k = 0; k < 4; k++) t[k+4*c] = b[k + 4*((c+k) & 3)];
      for (int c = 0; c < 4; c++) begin
         all = t[4*c] ^ t[4*c+1] ^ t[4*c+2] ^ t[4*c+3];
         for (int k = 0; k < 4; k++)
            m[4*c+k] = t[4*c+k] ^ all ^ xtime(t[4*c+k] ^ t[4*c+((k+1)&3)]);
      end
      for (int k = 0; k < 16; k++) o[127-8*k -: 8] = last ? t[k] : m[k];
      return o ^ rk;
   endfunction

   function automatic logic [127:0] key_step(input logic [127:0] k,
                                             input logic [7:0] rc);
      logic [31:0] w0, w1, w2, w3, g;
      w0 = k[127:96]; w1 = k[95:64]; w2 = k[63:32]; w3 = k[31:0];
      g  = {SBOX[w3[23:16]] ^ rc, SBOX[w3[15:8]], SBOX[w3[7:0]], SBOX[w3[31:24]]};
      w0 = w0 ^ g; w1 = w1 ^ w0; w2 = w2 ^ w1; w3 = w3 ^ w2;
      return {w0, w1, w2, w3};
   endfunction

endpackage

`default_nettype wire

### sv/ff1_binary_fpe_encrypt.sv
// Each of the 10 Feistel rounds runs 2 or 3 AES blocks, each through the whitening
// step and AES rounds 1 to 10, and the result then waits in the done state.
// Beats are not overlapped: one AES round unit serves every block of every beat.
// req_stall is high from acceptance until the result beat is taken.
// Reset clears the configuration registers and the sequencer; no clearing pass.
// ----------------------------------------------------------------------------
// FF1 radix-2 encryptor
// Sequential FF1 with AES-128 CBC-MAC PRF on one shared AES round unit.
// ----------------------------------------------------------------------------
`default_nettype none

module ff1_binary_fpe_encrypt #(
   parameter int unsigned MAX_TWEAK_BYTES = ff1_pkg::MaxTweakBytes
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic        req_func,
   input  wire logic [63:0] req_plain_word,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [63:0]      rsp_cipher_word,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [2:0]  csr_index,
   input  wire logic [63:0] csr_data
);

   typedef enum logic [1:0] {ST_IDLE, ST_BLOCK, ST_DONE} state_type;

   state_type    state_ff;
   logic [127:0] key_ff, tweak_ff;
   logic [4:0]   tlen_ff;
   logic         wide_ff;
   logic [31:0]  a_ff, b_ff;
   logic [3:0]   fround_ff;
   logic [1:0]   blk_ff;
   logic [3:0]   aes_ff;
   logic [127:0] x_ff, rk_ff;
   logic [63:0]  rsp_ff;

   logic [4:0]   tlen;
   logic [127:0] hdr, q0, q1, qblk, tmask, bfield, rk_next, x_rnd;
   logic [1:0]   nblk;
   logic [31:0]  y, sum, hmask;
   logic [5:0]   half;

   assign csr_ready = (state_ff == ST_IDLE);
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = (state_ff == ST_DONE);
   assign rsp_cipher_word = rsp_ff;

   always_comb begin
      tlen = (tlen_ff > 5'(MAX_TWEAK_BYTES)) ? 5'(MAX_TWEAK_BYTES) : tlen_ff;
      if (tlen > 5'd16) tlen = 5'd16;
      half  = wide_ff ? 6'd32 : 6'd16;
      hmask = wide_ff ? 32'hffffffff : 32'h0000ffff;
      hdr = {8'd1, 8'd2, 8'd1, 8'd0, 8'd0, 8'd2, 8'(ff1_pkg::FeistelRounds), 2'b0, half,
             24'd0, 1'b0, half, 1'b0, 24'd0, 3'd0, tlen};
      tmask = ~(128'hffff_ffff_ffff_ffff_ffff_ffff_ffff_ffff >> {tlen, 3'b000});
      if (tlen == 5'd0) tmask = '0;
      // Round byte then B, big-endian, at the tail of Q.
      bfield = wide_ff ? {88'd0, 4'd0, fround_ff, b_ff}
                       : {104'd0, 4'd0, fround_ff, b_ff[15:0]};
      // Tail fits in one block when t + nb + 1 <= 16.
      if ({1'b0, tlen} + (wide_ff ? 6'd5 : 6'd3) <= 6'd16) begin
         nblk = 2'd2;
         q0 = (tweak_ff & tmask) | bfield;
         q1 = '0;
      end else begin
         nblk = 2'd3;
         q0 = tweak_ff & tmask;
         q1 = bfield;
      end
      qblk = (blk_ff == 2'd1) ? q0 : q1;
      rk_next = ff1_pkg::key_step(rk_ff, ff1_pkg::RCON[aes_ff - 4'd1]);
      x_rnd = ff1_pkg::aes_round(x_ff, rk_next, aes_ff == 4'(ff1_pkg::AesRounds));
      // The first eight PRF bytes form a 64-bit number; only its low half bits count.
      y   = wide_ff ? x_rnd[95:64] : {16'd0, x_rnd[79:64]};
      sum = (a_ff + y) & hmask;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         key_ff   <= '0;
         tweak_ff <= '0;
         tlen_ff  <= '0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (csr_valid) begin
                  case (csr_index)
                     ff1_pkg::CSR_KEY_HIGH:   key_ff[127:64]   <= csr_data;
                     ff1_pkg::CSR_KEY_LOW:    key_ff[63:0]     <= csr_data;
                     ff1_pkg::CSR_TWEAK_HIGH: tweak_ff[127:64] <= csr_data;
                     ff1_pkg::CSR_TWEAK_LOW:  tweak_ff[63:0]   <= csr_data;
                     ff1_pkg::CSR_TWEAK_LEN:  tlen_ff          <= csr_data[4:0];
                     default: ;
                  endcase
               end
               if (req_valid) begin
                  wide_ff   <= req_func;
                  a_ff      <= req_func ? req_plain_word[63:32] : {16'd0, req_plain_word[31:16]};
                  b_ff      <= req_func ? req_plain_word[31:0] : {16'd0, req_plain_word[15:0]};
                  fround_ff <= '0;
                  blk_ff    <= '0;
                  aes_ff    <= '0;
                  state_ff  <= ST_BLOCK;
               end
            end
            ST_BLOCK: begin
               if (aes_ff == 4'd0) begin
                  // Whitening step: load block input and add round key 0.
                  rk_ff  <= key_ff;
                  x_ff   <= ((blk_ff == 2'd0) ? hdr : (x_ff ^ qblk)) ^ key_ff;
                  aes_ff <= 4'd1;
               end else begin
                  rk_ff <= rk_next;
                  x_ff  <= x_rnd;
                  if (aes_ff == 4'(ff1_pkg::AesRounds)) begin
                     aes_ff <= 4'd0;
                     if (blk_ff == nblk - 2'd1) begin
                        blk_ff <= 2'd0;
                        // x_rnd holds the PRF output here.
                        a_ff <= b_ff;
                        b_ff <= sum;
                        if (fround_ff == 4'(ff1_pkg::FeistelRounds - 1)) begin
                           state_ff <= ST_DONE;
                           rsp_ff <= wide_ff ? {b_ff, sum} : {32'd0, b_ff[15:0], sum[15:0]};
                        end
                        fround_ff <= fround_ff + 4'd1;
                     end else begin
                        blk_ff <= blk_ff + 2'd1;
                     end
                  end else begin
                     aes_ff <= aes_ff + 4'd1;
                  end
               end
            end
            ST_DONE: begin
               if (!rsp_stall) state_ff <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> req_stall) else $error("accept while busy");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_cipher_word)))
      else $error("result dropped");
   a_narrow_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !wide_ff) |-> (rsp_cipher_word[63:32] == 32'd0))
      else $error("upper half set in narrow mode");
   a_aes_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_BLOCK) |-> (aes_ff <= 4'(ff1_pkg::AesRounds)))
      else $error("aes round count overrun");

endmodule

`default_nettype wire
